/* src/boc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and tables for the open-loop six-step commutator
// no dependencies

package boc_pkg;

    localparam int PWM_PERIOD_COUNTS = 1024;
    localparam int NUM_STEPS         = 6;

    localparam int PERIOD_W  = 16;
    localparam int DUTY_W    = 7;
    localparam int STEP_W    = 3;
    localparam int OFFC_W    = 11;
    localparam int GATE_W    = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [PERIOD_W-1:0] COUNT_MAX = '1;

    // register reset values
    localparam logic [PERIOD_W-1:0] START_PERIOD_RESET  = 16'd120;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET    = 16'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_STEP_RESET   = 16'd1;
    localparam logic [PERIOD_W-1:0] RAMP_INTERVAL_RESET = 16'd300;
    localparam logic [DUTY_W-1:0]   DUTY_RESET          = 7'd0;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    // gate bit positions
    localparam logic [GATE_W-1:0] G_AH = 6'b000001;
    localparam logic [GATE_W-1:0] G_AL = 6'b000010;
    localparam logic [GATE_W-1:0] G_BH = 6'b000100;
    localparam logic [GATE_W-1:0] G_BL = 6'b001000;
    localparam logic [GATE_W-1:0] G_CH = 6'b010000;
    localparam logic [GATE_W-1:0] G_CL = 6'b100000;
    localparam logic [GATE_W-1:0] GATES_OFF = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_PERIOD  = 3'd0,
        REG_MIN_PERIOD    = 3'd1,
        REG_PERIOD_STEP   = 3'd2,
        REG_RAMP_INTERVAL = 3'd3,
        REG_DUTY          = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] start_period;
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] period_step;
        logic [PERIOD_W-1:0] ramp_interval;
        logic [DUTY_W-1:0]   duty;
    } cfg_t;

    typedef struct packed {
        logic                load;
        logic [PERIOD_W-1:0] value;
    } period_load_t;

    typedef struct packed {
        logic [GATE_W-1:0]   gates;
        logic [STEP_W-1:0]   next_step;
        logic                commutated;
        logic [PERIOD_W-1:0] period;
        logic [OFFC_W-1:0]   off_compare;
    } result_t;

    typedef logic [OFFC_W-1:0] off_table_t [2**DUTY_W];

    // clockwise six-step table
    function automatic logic [GATE_W-1:0] cw_pattern(input logic [STEP_W-1:0] step);
        logic [GATE_W-1:0] p;
        case (step)
            3'd0:    p = G_AH | G_BL;
            3'd1:    p = G_CH | G_BL;
            3'd2:    p = G_CH | G_AL;
            3'd3:    p = G_BH | G_AL;
            3'd4:    p = G_BH | G_CL;
            3'd5:    p = G_AH | G_CL;
            default: p = G_AH | G_BL;
        endcase
        return p;
    endfunction

    // off-compare per duty code, evaluated at elaboration, duty clamped to 100
    function automatic off_table_t build_off_table();
        off_table_t t;
        int d;
        for (int i = 0; i < 2**DUTY_W; i++)
        begin
            d = (i > 100) ? 100 : i;
            t[i] = OFFC_W'(PWM_PERIOD_COUNTS - (d * PWM_PERIOD_COUNTS) / 100);
        end
        return t;
    endfunction

    localparam off_table_t OFF_TABLE = build_off_table();

endpackage

`default_nettype wire

/* src/bldc_open_loop_commutator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// top level of the open-loop six-step bldc commutator
// depends on boc_pkg, boc_cfg, boc_core

// Each input transaction is one timer tick carrying a run flag; each tick
// produces exactly one output transaction with the six gate enables, the
// step to apply at the next commutation, a commutated flag, the period after
// this tick's ramp update and the pwm off-compare value. The counter and
// ramp update is a single pass of compare and subtract logic from the state
// registers into one result register, so a new tick is taken every cycle
// that in_ready is high, including the cycle in which the held result is
// taken downstream. in_ready drops only while the result register
// is full and out_ready is low. Configuration writes take effect at the
// clock edge they occur on; a write of the start period also reloads the
// running period. Writes to indexes beyond the duty register are ignored.

module bldc_open_loop_commutator_unit
    import boc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PERIOD_W-1:0]  cfg_wdata,
    // tick input
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 run,
    // result output
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      gate_a_high,
    output logic                      gate_a_low,
    output logic                      gate_b_high,
    output logic                      gate_b_low,
    output logic                      gate_c_high,
    output logic                      gate_c_low,
    output logic [STEP_W-1:0]         next_step,
    output logic                      commutated,
    output logic [PERIOD_W-1:0]       current_period,
    output logic [OFFC_W-1:0]         pwm_off_compare
);

    cfg_t         cfg;
    period_load_t period_load;
    result_t      result;
    logic         in_accept;

    // result register and its valid flag
    result_t result_reg;
    logic    out_valid_reg, out_valid_next;

    boc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cfg         (cfg),
        .period_load (period_load)
    );

    // state advances only on an accepted tick
    boc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (in_accept),
        .run         (run),
        .cfg         (cfg),
        .period_load (period_load),
        .result      (result)
    );

    // take a new tick whenever the result slot is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign gate_a_high     = |(result_reg.gates & G_AH);
    assign gate_a_low      = |(result_reg.gates & G_AL);
    assign gate_b_high     = |(result_reg.gates & G_BH);
    assign gate_b_low      = |(result_reg.gates & G_BL);
    assign gate_c_high     = |(result_reg.gates & G_CH);
    assign gate_c_low      = |(result_reg.gates & G_CL);
    assign next_step       = result_reg.next_step;
    assign commutated      = result_reg.commutated;
    assign current_period  = result_reg.period;
    assign pwm_off_compare = result_reg.off_compare;

    // a commutation always drives exactly one high side and one low side
    a_comm_two_gates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && commutated |-> $countones(result_reg.gates) == 2)
        else $error("commutation without a two-gate pattern");

    // never both switches of one phase at once
    a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(gate_a_high && gate_a_low) && !(gate_b_high && gate_b_low)
                      && !(gate_c_high && gate_c_low))
        else $error("shoot-through pattern on a phase");

    // step index stays within the six-step table
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> next_step <= LAST_STEP)
        else $error("step index out of range");

    // an accepted tick always leaves a result behind
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick produced no result");

endmodule

`default_nettype wire

/* src/boc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// configuration register file for the commutator
// depends on boc_pkg

module boc_cfg
    import boc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PERIOD_W-1:0]  cfg_wdata,
    output cfg_t                      cfg,
    output period_load_t              period_load
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next         = cfg_reg;
        period_load.load  = 1'b0;
        period_load.value = cfg_wdata;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_PERIOD:
                begin
                    cfg_next.start_period = cfg_wdata;
                    period_load.load      = 1'b1;
                end
                REG_MIN_PERIOD:    cfg_next.min_period    = cfg_wdata;
                REG_PERIOD_STEP:   cfg_next.period_step   = cfg_wdata;
                REG_RAMP_INTERVAL: cfg_next.ramp_interval = cfg_wdata;
                REG_DUTY:          cfg_next.duty          = cfg_wdata[DUTY_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_period  <= START_PERIOD_RESET;
            cfg_reg.min_period    <= MIN_PERIOD_RESET;
            cfg_reg.period_step   <= PERIOD_STEP_RESET;
            cfg_reg.ramp_interval <= RAMP_INTERVAL_RESET;
            cfg_reg.duty          <= DUTY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/boc_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// commutation state: tick and ramp counters, step index, period, gate pattern
// depends on boc_pkg

module boc_core
    import boc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   step_en,
    input  wire logic   run,
    input  wire cfg_t   cfg,
    input  wire period_load_t period_load,
    output result_t     result
);

    logic [PERIOD_W-1:0] tick_count_reg,   tick_count_next;
    logic [PERIOD_W-1:0] ramp_count_reg,   ramp_count_next;
    logic [STEP_W-1:0]   step_index_reg,   step_index_next;
    logic [PERIOD_W-1:0] period_ticks_reg, period_ticks_next;
    logic [GATE_W-1:0]   gate_pattern_reg, gate_pattern_next;

    logic [PERIOD_W-1:0] tick_inc;
    logic [PERIOD_W-1:0] ramp_inc;
    logic                comm;

    assign tick_inc = (tick_count_reg == COUNT_MAX) ? COUNT_MAX : tick_count_reg + 1'b1;
    assign ramp_inc = (ramp_count_reg == COUNT_MAX) ? COUNT_MAX : ramp_count_reg + 1'b1;

    always_comb
    begin
        tick_count_next   = tick_inc;
        ramp_count_next   = ramp_inc;
        step_index_next   = step_index_reg;
        period_ticks_next = period_ticks_reg;
        gate_pattern_next = gate_pattern_reg;
        comm              = 1'b0;
        if (!run)
        begin
            gate_pattern_next = GATES_OFF;
        end
        else
        begin
            // compare against the period before this tick's ramp update
            if (tick_inc >= period_ticks_reg)
            begin
                comm              = 1'b1;
                gate_pattern_next = cw_pattern(step_index_reg);
                step_index_next   = (step_index_reg >= LAST_STEP) ? '0
                                    : step_index_reg + 1'b1;
                tick_count_next   = '0;
            end
            if (ramp_inc >= cfg.ramp_interval)
            begin
                if (period_ticks_reg > cfg.min_period)
                begin
                    period_ticks_next = (period_ticks_reg > cfg.period_step)
                                        ? period_ticks_reg - cfg.period_step : '0;
                end
                ramp_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            ramp_count_reg   <= '0;
            step_index_reg   <= '0;
            period_ticks_reg <= START_PERIOD_RESET;
            gate_pattern_reg <= GATES_OFF;
        end
        else if (period_load.load)
        begin
            period_ticks_reg <= period_load.value;
        end
        else if (step_en)
        begin
            tick_count_reg   <= tick_count_next;
            ramp_count_reg   <= ramp_count_next;
            step_index_reg   <= step_index_next;
            period_ticks_reg <= period_ticks_next;
            gate_pattern_reg <= gate_pattern_next;
        end
    end

    always_comb
    begin
        result.gates       = gate_pattern_next;
        result.next_step   = step_index_next;
        result.commutated  = comm;
        result.period      = period_ticks_next;
        result.off_compare = OFF_TABLE[cfg.duty];
    end

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
// self-checking bench for the open-loop six-step commutator unit
// depends on boc_pkg and bldc_open_loop_commutator_unit

module testbench
    import boc_pkg::*;
();

    // sender / receiver pacing modes used across phases
    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_GAPS,
        FLOW_RECEIVER_STALLS,
        FLOW_BOTH
    } flow_mode_t;

    localparam int GAP_PCT        = 78;
    localparam int BOTH_PCT       = 22;
    localparam int LONG_HOLD      = 300;     // receiver hold-off that fills the block
    localparam int QUIET_LIMIT    = 5000;    // cycles without any transaction
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_TICKS    = 100;
    localparam int NUM_PHASES     = 8;
    localparam int STOP_TICKS     = 20;      // stopped stretch before the final restart

    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(REG_DUTY + 1);

    // clockwise sequence, entry i is the pattern applied at step i
    localparam logic [NUM_STEPS-1:0][GATE_W-1:0] CW_SEQUENCE = {
        G_AH | G_CL, G_BH | G_CL, G_BH | G_AL, G_CH | G_AL, G_CH | G_BL, G_AH | G_BL
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PERIOD_W-1:0]  cfg_wdata = '0;

    logic                 in_valid = 1'b0;
    logic                 run = 1'b0;
    wire logic            in_ready;

    wire logic            out_valid;
    logic                 out_ready = 1'b0;
    wire logic            gate_a_high;
    wire logic            gate_a_low;
    wire logic            gate_b_high;
    wire logic            gate_b_low;
    wire logic            gate_c_high;
    wire logic            gate_c_low;
    wire logic [STEP_W-1:0]   next_step;
    wire logic                commutated;
    wire logic [PERIOD_W-1:0] current_period;
    wire logic [OFFC_W-1:0]   pwm_off_compare;

    bldc_open_loop_commutator_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .run             (run),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .gate_a_high     (gate_a_high),
        .gate_a_low      (gate_a_low),
        .gate_b_high     (gate_b_high),
        .gate_b_low      (gate_b_low),
        .gate_c_high     (gate_c_high),
        .gate_c_low      (gate_c_low),
        .next_step       (next_step),
        .commutated      (commutated),
        .current_period  (current_period),
        .pwm_off_compare (pwm_off_compare)
    );

    // ------------------------------------------------------------------
    // shadow of the commutator: register copy plus the running state
    // ------------------------------------------------------------------
    cfg_t                reg_shadow;
    logic [PERIOD_W-1:0] mdl_tick;
    logic [PERIOD_W-1:0] mdl_ramp;
    logic [STEP_W-1:0]   mdl_step;
    logic [PERIOD_W-1:0] mdl_period;
    logic [GATE_W-1:0]   mdl_gates;

    // run flags waiting to be offered, and outputs predicted per accepted tick
    logic    tick_backlog [$];
    result_t predicted_outputs [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;

    int ticks_accepted = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int stray_results = 0;
    int commutations_seen = 0;
    int period_cuts = 0;
    int stopped_ticks = 0;
    int settings_applied = 0;

    // apply one register write to the shadow; unknown indexes do nothing
    task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                input logic [PERIOD_W-1:0] data);
        case (idx)
            REG_START_PERIOD:
            begin
                reg_shadow.start_period = data;
                mdl_period = data;  // start period also reloads the running period
            end
            REG_MIN_PERIOD:    reg_shadow.min_period = data;
            REG_PERIOD_STEP:   reg_shadow.period_step = data;
            REG_RAMP_INTERVAL: reg_shadow.ramp_interval = data;
            REG_DUTY:          reg_shadow.duty = data[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // one timer tick through the shadow, returns the outputs it should produce
    function automatic result_t commutate_tick(input logic running);
        result_t r;
        int      duty_eff;
        if (mdl_tick != COUNT_MAX)
            mdl_tick = mdl_tick + 1'b1;
        if (mdl_ramp != COUNT_MAX)
            mdl_ramp = mdl_ramp + 1'b1;
        r.commutated = 1'b0;
        if (!running)
        begin
            mdl_gates = GATES_OFF;
            stopped_ticks++;
        end
        else
        begin
            if (mdl_tick >= mdl_period)
            begin
                mdl_gates  = CW_SEQUENCE[mdl_step];
                mdl_step   = (mdl_step >= LAST_STEP) ? '0 : mdl_step + 1'b1;
                mdl_tick   = '0;
                r.commutated = 1'b1;
                commutations_seen++;
            end
            if (mdl_ramp >= reg_shadow.ramp_interval)
            begin
                if (mdl_period > reg_shadow.min_period)
                begin
                    mdl_period = (mdl_period > reg_shadow.period_step)
                               ? mdl_period - reg_shadow.period_step : '0;
                    period_cuts++;
                end
                mdl_ramp = '0;
            end
        end
        duty_eff = (reg_shadow.duty > 100) ? 100 : int'(reg_shadow.duty);
        r.gates       = mdl_gates;
        r.next_step   = mdl_step;
        r.period      = mdl_period;
        r.off_compare = OFFC_W'(PWM_PERIOD_COUNTS - (duty_eff * PWM_PERIOD_COUNTS) / 100);
        return r;
    endfunction

    function automatic cfg_t make_setting(input int start_p, input int min_p,
                                          input int step_p, input int ramp_p,
                                          input int duty_p);
        cfg_t s;
        s.start_period  = PERIOD_W'(start_p);
        s.min_period    = PERIOD_W'(min_p);
        s.period_step   = PERIOD_W'(step_p);
        s.ramp_interval = PERIOD_W'(ramp_p);
        s.duty          = DUTY_W'(duty_p);
        return s;
    endfunction

    // mostly short periods and ramps so commutation and ramp-down happen often
    function automatic cfg_t random_setting();
        return make_setting($urandom_range(0, 16), $urandom_range(0, 10),
                            $urandom_range(0, 3), $urandom_range(0, 12),
                            $urandom_range(0, 127));
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // tick driver: offers backlog entries, predicts on each accepted transaction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            run      <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_outputs.push_back(commutate_tick(run));
                ticks_accepted++;
            end
            // only move on when nothing is held or the held tick just went in
            if (!in_valid || in_ready)
            begin
                if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    run      <= tick_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    run      <= 1'($urandom_range(0, 1));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver pacing
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, name, want, got);
        end
    endtask

    result_t head_result;
    int      hold_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    stray_results++;
                    if (stray_results <= REPORT_LIMIT)
                        $display("result %0d arrived with no tick waiting for it",
                                 results_seen);
                end
                else
                begin
                    head_result = predicted_outputs.pop_front();
                    check_field("gate_a_high", head_result.gates[0], gate_a_high);
                    check_field("gate_a_low", head_result.gates[1], gate_a_low);
                    check_field("gate_b_high", head_result.gates[2], gate_b_high);
                    check_field("gate_b_low", head_result.gates[3], gate_b_low);
                    check_field("gate_c_high", head_result.gates[4], gate_c_high);
                    check_field("gate_c_low", head_result.gates[5], gate_c_low);
                    check_field("next_step", head_result.next_step, next_step);
                    check_field("commutated", head_result.commutated, commutated);
                    check_field("current_period", head_result.period, current_period);
                    check_field("pwm_off_compare", head_result.off_compare,
                                pwm_off_compare);
                end
                results_seen++;
            end
            // one long hold-off on request, counted here
            if (hold_armed && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run when neither side moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no transaction for %0d cycles, %0d ticks still predicted",
                         QUIET_LIMIT, predicted_outputs.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequencing
    // ------------------------------------------------------------------

    // wait until every queued tick is in and every predicted output is out,
    // checked away from the driving edge, then line up on a rising edge
    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_backlog.size() != 0 || in_valid || predicted_outputs.size() != 0);
        @(posedge clk);
    endtask

    // one register write, launched right after a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [PERIOD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        shadow_write(idx, data);
        @(posedge clk);
    endtask

    // program all five registers while idle, plus a write to an unused index
    task automatic apply_setting(input cfg_t s);
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, 2**CFG_IDX_W - 1));
        wait_drained();
        write_reg(REG_MIN_PERIOD, s.min_period);
        write_reg(REG_PERIOD_STEP, s.period_step);
        write_reg(REG_RAMP_INTERVAL, s.ramp_interval);
        // upper data bits are don't-care for the duty register
        write_reg(REG_DUTY, {PERIOD_W'($urandom_range(0, 2**(PERIOD_W - DUTY_W) - 1))
                             << DUTY_W} | PERIOD_W'(s.duty));
        write_reg(spare, PERIOD_W'($urandom_range(0, 2**PERIOD_W - 1)));
        write_reg(REG_START_PERIOD, s.start_period);
        cfg_we    <= 1'b0;
        cfg_index <= CFG_IDX_W'($urandom_range(0, 2**CFG_IDX_W - 1));
        cfg_wdata <= PERIOD_W'($urandom_range(0, 2**PERIOD_W - 1));
        settings_applied++;
    endtask

    task automatic set_flow(input flow_mode_t mode);
        @(negedge clk);
        case (mode)
            FLOW_FREE:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            FLOW_SENDER_GAPS:
            begin
                sender_idle_pct    = GAP_PCT;
                receiver_stall_pct = 0;
            end
            FLOW_RECEIVER_STALLS:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = GAP_PCT;
            end
            default:
            begin
                sender_idle_pct    = BOTH_PCT;
                receiver_stall_pct = BOTH_PCT;
            end
        endcase
    endtask

    task automatic queue_ticks(input int count, input logic running);
        @(negedge clk);
        repeat (count)
            tick_backlog.push_back(running);
    endtask

    // random run flags, running on run_pct percent of the ticks
    task automatic queue_random_ticks(input int count, input int run_pct);
        @(negedge clk);
        repeat (count)
            tick_backlog.push_back($urandom_range(0, 99) < run_pct);
    endtask

    cfg_t phase_setting;

    initial
    begin
        // shadow starts from the reset state
        reg_shadow = make_setting(START_PERIOD_RESET, MIN_PERIOD_RESET, PERIOD_STEP_RESET,
                                  RAMP_INTERVAL_RESET, DUTY_RESET);
        mdl_tick   = '0;
        mdl_ramp   = '0;
        mdl_step   = '0;
        mdl_period = START_PERIOD_RESET;
        mdl_gates  = GATES_OFF;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset values seen through a few ticks
        set_flow(FLOW_FREE);
        queue_ticks(2, 1'b1);
        queue_ticks(1, 1'b0);

        // period of one: every running tick commutates, walks the whole table and wraps
        apply_setting(make_setting(1, 0, 0, 16'hFFFF, 100));
        queue_ticks(7, 1'b1);

        // stop then restart: gates stay off until the next commutation, duty above 100
        apply_setting(make_setting(3, 0, 0, 16'hFFFF, 127));
        queue_ticks(3, 1'b1);
        queue_ticks(1, 1'b0);
        queue_ticks(2, 1'b1);

        // zero period commutates on every tick, zero ramp interval acts every tick
        apply_setting(make_setting(0, 2, 5, 0, 0));
        queue_ticks(2, 1'b1);

        // step larger than the period saturates at zero and stays below minimum
        apply_setting(make_setting(4, 2, 5, 0, 50));
        queue_ticks(3, 1'b1);

        // random phases, each pacing mode in turn, first settings at the extremes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_setting = make_setting(0, 16'hFFFF, 0, 0, 100);
                1: phase_setting = make_setting(3, 0, 16'hFFFF, 1, 127);
                2: phase_setting = make_setting(16'hFFFF, 4, 16'h2000, 0, 0);
                default: phase_setting = random_setting();
            endcase
            apply_setting(phase_setting);
            set_flow(flow_mode_t'(p % 4));
            // free-flowing phase with a long receiver hold-off to back up the input
            if (p == 4)
                hold_armed = 1'b1;
            queue_random_ticks(PHASE_TICKS, (p == 6) ? 50 : 90);
        end

        // stopped stretch, then restart at the largest period
        apply_setting(make_setting(16'hFFFF, 0, 16'h0FFF, 16'hFFFF, $urandom_range(0, 127)));
        set_flow(FLOW_FREE);
        queue_ticks(STOP_TICKS, 1'b0);
        queue_random_ticks(40, 90);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d ticks over %0d register settings, %0d of them stopped",
                 ticks_accepted, settings_applied, stopped_ticks);
        $display("saw %0d commutations and %0d period reductions, %0d bad fields, %0d stray",
                 commutations_seen, period_cuts, mismatch_count, stray_results);
        if (mismatch_count == 0 && stray_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/boc_pkg.sv
src/boc_cfg.sv
src/boc_core.sv
src/bldc_open_loop_commutator_unit.sv
bench/testbench.sv
